@@ rtl/core/kce_pkg.sv @@
// kce_pkg: shared constants, types and register codes of the k-means engine
// no dependencies; imported by the interfaces and every module of the core

package kce_pkg;

  localparam int MAX_POINTS   = 64;
  localparam int MAX_CLUSTERS = 8;
  localparam int MAX_FEATURES = 4;
  localparam int FEATURE_BITS = 16;

  localparam int PIDX_W = 6;    // point index
  localparam int PCNT_W = 7;    // point count, holds MAX_POINTS itself
  localparam int CID_W  = 3;    // cluster index
  localparam int SUM_W  = 22;   // signed per-cluster feature sum
  localparam int SQ_W   = 32;   // one squared difference
  localparam int DIST_W = 34;   // sum of four squared differences
  localparam int CHG_W  = 37;   // summed change over all centroid features
  localparam int THR_W  = 36;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 36;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_CLUSTERS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_FEATURES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CONV_THR     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_SEED    = 3'd4;

  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  typedef logic signed [FEATURE_BITS-1:0] feat_t;
  typedef feat_t [MAX_FEATURES-1:0]        point_t;
  typedef logic [DIST_W-1:0]               dist_t;
  typedef dist_t [MAX_CLUSTERS-1:0]        dist_vec_t;

endpackage

@@ rtl/core/kce_ifs.sv @@
// kce_ifs: valid/ready channel interfaces for point input, result output and config
// depends on kce_pkg

interface kce_in_if;
  import kce_pkg::*;
  logic  valid;
  logic  ready;
  feat_t feature_a;
  feat_t feature_b;
  feat_t feature_c;
  feat_t feature_d;
  logic  last_point;
  modport source (output valid, feature_a, feature_b, feature_c, feature_d, last_point,
                  input ready);
  modport sink   (input valid, feature_a, feature_b, feature_c, feature_d, last_point,
                  output ready);
endinterface

interface kce_out_if;
  import kce_pkg::*;
  logic              valid;
  logic              ready;
  logic [PIDX_W-1:0] point_index;
  logic [CID_W-1:0]  cluster_id;
  logic              converged;
  logic              overflowed;
  logic              last_result;
  modport source (output valid, point_index, cluster_id, converged, overflowed, last_result,
                  input ready);
  modport sink   (input valid, point_index, cluster_id, converged, overflowed, last_result,
                  output ready);
endinterface

interface kce_cfg_if;
  import kce_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/kmeans_cluster_engine_core.sv @@
// kmeans_cluster_engine_core: top level of the Lloyd k-means engine
// depends on kce_pkg, kce_ifs, kce_lane, kce_merge, kce_div

// Points load one word per cycle into a 64-entry store while in_if.ready is high.
// A word with last_point set closes the set: input then stalls while the engine
// clusters. Seeding runs per cluster through an LFSR step, a serial modulo in the
// shared divider, a store read and a centroid write. Each pass streams every
// stored point through eight parallel distance lanes and a merge tree, then
// updates each centroid feature through the shared serial divider, over 4k
// features, skipping the divide for an unused feature or an empty cluster, and
// ends in a decision state. Results leave in load order, limited by the registered
// read of the assignment store. Config writes are taken only while the engine
// waits for points; cfg_if.ready stays low while it clusters and sends results.
// Points beyond 64 are dropped and flagged.

module kmeans_cluster_engine_core (
  input  logic clk,
  input  logic rst_n,
  kce_in_if.sink    in_if,
  kce_out_if.source out_if,
  kce_cfg_if.sink   cfg_if
);
  import kce_pkg::*;

  typedef enum logic [10:0] {
    S_LOAD      = 11'b00000000001,
    S_SEED_LFSR = 11'b00000000010,
    S_SEED_MOD  = 11'b00000000100,
    S_SEED_RD   = 11'b00000001000,
    S_SEED_WR   = 11'b00000010000,
    S_ASSIGN    = 11'b00000100000,
    S_UPD_DIV   = 11'b00001000000,
    S_UPD_CHG   = 11'b00010000000,
    S_DECIDE    = 11'b00100000000,
    S_EMIT_RD   = 11'b01000000000,
    S_EMIT_SHOW = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  // config registers
  logic [3:0]       nclus_r;
  logic [2:0]       nfeat_r;
  logic [THR_W-1:0] thr_r;
  logic [7:0]       maxit_r;
  logic [15:0]      lfsr_r;

  // effective settings after clamping
  logic [3:0]              k_eff;
  logic [2:0]              f_eff;
  logic [7:0]              limit;
  logic [MAX_FEATURES-1:0] fmask;
  logic [MAX_CLUSTERS-1:0] live;

  always_comb begin
    k_eff = (nclus_r == 4'd0) ? 4'd1 : (nclus_r > 4'(MAX_CLUSTERS)) ? 4'(MAX_CLUSTERS) : nclus_r;
    f_eff = (nfeat_r == 3'd0) ? 3'd1 : (nfeat_r > 3'(MAX_FEATURES)) ? 3'(MAX_FEATURES) : nfeat_r;
    limit = (maxit_r == 8'd0) ? 8'd1 : maxit_r;
    for (int j = 0; j < MAX_FEATURES; j++) fmask[j] = 3'(j) < f_eff;
    for (int c = 0; c < MAX_CLUSTERS; c++) live[c] = 4'(c) < k_eff;
  end

  logic cfg_wr;
  assign cfg_if.ready = (state_r == S_LOAD);
  assign cfg_wr       = cfg_if.valid && cfg_if.ready;

  // handshakes
  logic in_acc, out_acc;
  assign in_if.ready = (state_r == S_LOAD);
  assign in_acc      = in_if.valid && in_if.ready;
  assign out_acc     = out_if.valid && out_if.ready;

  // run state
  logic [PCNT_W-1:0] pcnt_r;
  logic              ovf_r;
  logic              conv_r;
  logic [7:0]        it_r;
  logic [CID_W-1:0]  sc_r;        // cluster being seeded
  logic [PIDX_W-1:0] pick_r;
  logic              div_go_r;    // divider launched for the current step
  logic [PCNT_W-1:0] a_r;         // assign issue counter
  logic [4:0]        u_r;         // update element {cluster, feature}
  logic [PIDX_W-1:0] e_r;         // emit pointer
  logic [CHG_W-1:0]  chg_r;
  logic [FEATURE_BITS-1:0] dabs_r;

  // point store, registered read
  logic [MAX_FEATURES*FEATURE_BITS-1:0] pmem [MAX_POINTS];
  logic [MAX_FEATURES*FEATURE_BITS-1:0] pmem_q_r;
  logic [PIDX_W-1:0] prd_addr;
  logic              pwr;

  assign pwr      = in_acc && (pcnt_r < PCNT_W'(MAX_POINTS));
  assign prd_addr = (state_r == S_ASSIGN) ? a_r[PIDX_W-1:0] : pick_r;

  always_ff @(posedge clk) begin
    if (pwr) begin
      pmem[pcnt_r[PIDX_W-1:0]] <= {in_if.feature_d, in_if.feature_c,
                                   in_if.feature_b, in_if.feature_a};
    end
    pmem_q_r <= pmem[prd_addr];
  end

  // assignment store, registered read
  logic [CID_W-1:0] amem [MAX_POINTS];
  logic [CID_W-1:0] amem_q_r;

  // centroids and fresh centroids
  point_t cent_r  [MAX_CLUSTERS];
  point_t fresh_r [MAX_CLUSTERS];

  // accumulators
  logic signed [SUM_W-1:0] sum_r  [MAX_CLUSTERS][MAX_FEATURES];
  logic [PCNT_W-1:0]       ccnt_r [MAX_CLUSTERS];
  logic                    clr_acc;

  // assignment pipeline
  logic              v0;
  logic              v1_r, v2_r, v3_r, v4_r;
  logic [PIDX_W-1:0] i1_r, i2_r, i3_r, i4_r;
  point_t            pt2_r, pt3_r, pt4_r;
  dist_vec_t         lane_dist;
  logic [CID_W-1:0]  best_r;

  assign v0 = (state_r == S_ASSIGN) && (a_r < pcnt_r);

  // one distance lane per cluster
  for (genvar c = 0; c < MAX_CLUSTERS; c++) begin : g_lane
    kce_lane u_lane (
      .clk    (clk),
      .pt     (point_t'(pmem_q_r)),
      .cent   (cent_r[c]),
      .fmask  (fmask),
      .dist_r (lane_dist[c])
    );
  end

  kce_merge u_merge (
    .clk       (clk),
    .lane_dist (lane_dist),
    .live      (live),
    .best_r    (best_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= v0;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    i1_r  <= a_r[PIDX_W-1:0];
    i2_r  <= i1_r;
    i3_r  <= i2_r;
    i4_r  <= i3_r;
    pt2_r <= point_t'(pmem_q_r);
    pt3_r <= pt2_r;
    pt4_r <= pt3_r;
  end

  // assignment write and emit read
  always_ff @(posedge clk) begin
    if (v4_r) amem[i4_r] <= best_r;
    amem_q_r <= amem[e_r];
  end

  // sums and counts per cluster
  always_ff @(posedge clk) begin
    if (!rst_n || clr_acc) begin
      for (int c = 0; c < MAX_CLUSTERS; c++) begin
        ccnt_r[c] <= '0;
        for (int j = 0; j < MAX_FEATURES; j++) sum_r[c][j] <= '0;
      end
    end else if (v4_r) begin
      ccnt_r[best_r] <= ccnt_r[best_r] + 1'b1;
      for (int j = 0; j < MAX_FEATURES; j++) begin
        if (fmask[j]) begin
          sum_r[best_r][j] <= sum_r[best_r][j] +
                              {{(SUM_W-FEATURE_BITS){pt4_r[j][FEATURE_BITS-1]}}, pt4_r[j]};
        end
      end
    end
  end

  // shared divider: seed modulo and centroid mean
  logic [CID_W-1:0]        uc;
  logic [1:0]              uj;
  logic signed [SUM_W-1:0] usum;
  logic                    uneg;
  logic                    uneed;
  logic                    div_start;
  logic [SUM_W-1:0]        div_dvd;
  logic [PCNT_W-1:0]       div_dvs;
  logic                    div_done;
  logic [SUM_W-1:0]        div_quo;
  logic [PCNT_W-1:0]       div_rem;
  logic signed [FEATURE_BITS-1:0] qval;
  logic signed [FEATURE_BITS-1:0] uold;
  logic signed [FEATURE_BITS:0]   qdiff;
  logic [FEATURE_BITS-1:0]        qabs;

  assign uc    = u_r[4:2];
  assign uj    = u_r[1:0];
  assign usum  = sum_r[uc][uj];
  assign uneg  = usum[SUM_W-1];
  assign uneed = fmask[uj] && (ccnt_r[uc] != '0);
  assign uold  = cent_r[uc][uj];

  assign div_dvd = (state_r == S_SEED_MOD) ? SUM_W'(lfsr_r)
                 : (uneg ? SUM_W'(-usum) : SUM_W'(usum));
  assign div_dvs = (state_r == S_SEED_MOD) ? pcnt_r : ccnt_r[uc];
  assign div_start = ((state_r == S_SEED_MOD) || (state_r == S_UPD_DIV && uneed)) && !div_go_r;

  kce_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done_r   (div_done),
    .quo_r    (div_quo),
    .rem_r    (div_rem)
  );

  // truncation toward zero: divide the magnitude, then restore the sign
  always_comb begin
    qval  = uneg ? FEATURE_BITS'(-div_quo[FEATURE_BITS-1:0]) : div_quo[FEATURE_BITS-1:0];
    qdiff = {qval[FEATURE_BITS-1], qval} - {uold[FEATURE_BITS-1], uold};
    qabs  = qdiff[FEATURE_BITS] ? FEATURE_BITS'(-qdiff) : qdiff[FEATURE_BITS-1:0];
  end

  // lfsr step: shift right, fold in taps when a one falls out
  logic [15:0] lfsr_step;
  assign lfsr_step = lfsr_r[0] ? ({1'b0, lfsr_r[15:1]} ^ LFSR_TAPS) : {1'b0, lfsr_r[15:1]};

  logic last_out;
  assign last_out = ({1'b0, e_r} == pcnt_r - 1'b1);

  logic [8:0] it_inc;
  assign it_inc = {1'b0, it_r} + 9'd1;

  // control
  always_comb begin
    state_nxt = state_r;
    clr_acc   = 1'b0;
    case (state_r)
      S_LOAD: begin
        if (in_acc && in_if.last_point) state_nxt = S_SEED_LFSR;
      end
      S_SEED_LFSR: state_nxt = S_SEED_MOD;
      S_SEED_MOD:  if (div_done) state_nxt = S_SEED_RD;
      S_SEED_RD:   state_nxt = S_SEED_WR;
      S_SEED_WR: begin
        if ({1'b0, sc_r} == k_eff - 1'b1) begin
          state_nxt = S_ASSIGN;
          clr_acc   = 1'b1;
        end else begin
          state_nxt = S_SEED_LFSR;
        end
      end
      S_ASSIGN: begin
        if (v4_r && ({1'b0, i4_r} == pcnt_r - 1'b1)) state_nxt = S_UPD_DIV;
      end
      S_UPD_DIV: begin
        if (!uneed || div_done) state_nxt = S_UPD_CHG;
      end
      S_UPD_CHG: begin
        if (({1'b0, uc} == k_eff - 1'b1) && (uj == 2'd3)) state_nxt = S_DECIDE;
        else state_nxt = S_UPD_DIV;
      end
      S_DECIDE: begin
        if (chg_r < CHG_W'(thr_r) || it_inc >= {1'b0, limit}) begin
          state_nxt = S_EMIT_RD;
        end else begin
          state_nxt = S_ASSIGN;
          clr_acc   = 1'b1;
        end
      end
      S_EMIT_RD:   state_nxt = S_EMIT_SHOW;
      S_EMIT_SHOW: begin
        if (out_acc) state_nxt = last_out ? S_LOAD : S_EMIT_RD;
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_LOAD;
      nclus_r  <= 4'd4;
      nfeat_r  <= 3'd2;
      thr_r    <= '0;
      maxit_r  <= 8'd100;
      lfsr_r   <= 16'd1;
      pcnt_r   <= '0;
      ovf_r    <= 1'b0;
      conv_r   <= 1'b0;
      it_r     <= '0;
      sc_r     <= '0;
      div_go_r <= 1'b0;
      a_r      <= '0;
      u_r      <= '0;
      e_r      <= '0;
      chg_r    <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_wr) begin
        case (cfg_if.index)
          CFG_NUM_CLUSTERS: nclus_r <= cfg_if.data[3:0];
          CFG_NUM_FEATURES: nfeat_r <= cfg_if.data[2:0];
          CFG_CONV_THR:     thr_r   <= cfg_if.data[THR_W-1:0];
          CFG_MAX_ITER:     maxit_r <= cfg_if.data[7:0];
          CFG_INIT_SEED:    lfsr_r  <= (cfg_if.data[15:0] == 16'd0) ? 16'd1 : cfg_if.data[15:0];
          default: ;
        endcase
      end

      if (div_start) div_go_r <= 1'b1;
      if (div_done)  div_go_r <= 1'b0;

      case (state_r)
        S_LOAD: begin
          if (pwr) pcnt_r <= pcnt_r + 1'b1;
          else if (in_acc) ovf_r <= 1'b1;
          sc_r <= '0;
          it_r <= '0;
        end
        S_SEED_LFSR: lfsr_r <= lfsr_step;
        S_SEED_MOD: if (div_done) pick_r <= div_rem[PIDX_W-1:0];
        S_SEED_WR: begin
          sc_r  <= sc_r + 1'b1;
          a_r   <= '0;
          chg_r <= '0;
        end
        S_ASSIGN: begin
          if (v0) a_r <= a_r + 1'b1;
          u_r <= '0;
        end
        S_UPD_CHG: begin
          chg_r <= chg_r + CHG_W'(dabs_r * dabs_r);
          u_r   <= u_r + 1'b1;
        end
        S_DECIDE: begin
          it_r  <= it_inc[7:0];
          a_r   <= '0;
          chg_r <= '0;
          e_r   <= '0;
          conv_r <= chg_r < CHG_W'(thr_r);
        end
        S_EMIT_SHOW: begin
          if (out_acc) begin
            if (last_out) begin
              pcnt_r <= '0;
              ovf_r  <= 1'b0;
            end else begin
              e_r <= e_r + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // centroid payload: seeding, fresh values, and the copy after a pass
  always_ff @(posedge clk) begin
    if (state_r == S_SEED_WR) cent_r[sc_r] <= point_t'(pmem_q_r);
    if (state_r == S_UPD_DIV) begin
      if (!uneed) begin
        fresh_r[uc][uj] <= uold;
        dabs_r          <= '0;
      end else if (div_done) begin
        fresh_r[uc][uj] <= qval;
        dabs_r          <= qabs;
      end
    end
    if (state_r == S_DECIDE && !(chg_r < CHG_W'(thr_r))) begin
      for (int c = 0; c < MAX_CLUSTERS; c++) begin
        if (live[c]) cent_r[c] <= fresh_r[c];
      end
    end
  end

  // result word
  assign out_if.valid       = (state_r == S_EMIT_SHOW);
  assign out_if.point_index = e_r;
  assign out_if.cluster_id  = amem_q_r;
  assign out_if.converged   = conv_r;
  assign out_if.overflowed  = ovf_r;
  assign out_if.last_result = last_out;

endmodule

@@ rtl/core/kce_lane.sv @@
// kce_lane: squared distance of one point to one centroid, two register stages
// depends on kce_pkg

module kce_lane (
  input  logic                                clk,
  input  kce_pkg::point_t                     pt,
  input  kce_pkg::point_t                     cent,
  input  logic [kce_pkg::MAX_FEATURES-1:0]    fmask,
  output kce_pkg::dist_t                      dist_r
);
  import kce_pkg::*;

  logic signed [FEATURE_BITS:0] diff [MAX_FEATURES];
  logic [FEATURE_BITS-1:0]      mag  [MAX_FEATURES];
  logic [SQ_W-1:0]              sq_r [MAX_FEATURES];
  logic [DIST_W-1:0]            acc;

  always_comb begin
    for (int j = 0; j < MAX_FEATURES; j++) begin
      diff[j] = {pt[j][FEATURE_BITS-1], pt[j]} - {cent[j][FEATURE_BITS-1], cent[j]};
      mag[j]  = diff[j][FEATURE_BITS] ? FEATURE_BITS'(-diff[j]) : diff[j][FEATURE_BITS-1:0];
    end
  end

  // squares of masked features
  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_FEATURES; j++) begin
      sq_r[j] <= fmask[j] ? SQ_W'(mag[j] * mag[j]) : '0;
    end
  end

  always_comb begin
    acc = '0;
    for (int j = 0; j < MAX_FEATURES; j++) begin
      acc = acc + DIST_W'(sq_r[j]);
    end
  end

  always_ff @(posedge clk) begin
    dist_r <= acc;
  end

endmodule

@@ rtl/core/kce_merge.sv @@
// kce_merge: picks the nearest live lane, ties to the lower cluster, registered
// depends on kce_pkg

module kce_merge (
  input  logic                                clk,
  input  kce_pkg::dist_vec_t                  lane_dist,
  input  logic [kce_pkg::MAX_CLUSTERS-1:0]    live,
  output logic [kce_pkg::CID_W-1:0]           best_r
);
  import kce_pkg::*;

  typedef struct packed {
    logic              v;
    dist_t             d;
    logic [CID_W-1:0]  idx;
  } node_t;

  function automatic node_t pick(input node_t a, input node_t b);
    node_t r;
    if (!b.v) r = a;
    else if (!a.v) r = b;
    else if (b.d < a.d) r = b;
    else r = a;
    return r;
  endfunction

  node_t l0 [8];
  node_t l1 [4];
  node_t l2 [2];
  node_t top;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      l0[i].v   = live[i];
      l0[i].d   = lane_dist[i];
      l0[i].idx = CID_W'(i);
    end
    for (int i = 0; i < 4; i++) l1[i] = pick(l0[2*i], l0[2*i+1]);
    for (int i = 0; i < 2; i++) l2[i] = pick(l1[2*i], l1[2*i+1]);
    top = pick(l2[0], l2[1]);
  end

  always_ff @(posedge clk) begin
    best_r <= top.idx;
  end

endmodule

@@ rtl/core/kce_div.sv @@
// kce_div: restoring unsigned divider, one quotient bit per cycle
// depends on kce_pkg; shared by seed selection and centroid update

module kce_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [kce_pkg::SUM_W-1:0]    dividend,
  input  logic [kce_pkg::PCNT_W-1:0]   divisor,
  output logic                         done_r,
  output logic [kce_pkg::SUM_W-1:0]    quo_r,
  output logic [kce_pkg::PCNT_W-1:0]   rem_r
);
  import kce_pkg::*;

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [PCNT_W:0]  trial;
  logic             ge;

  assign trial = {rem_r, quo_r[SUM_W-1]};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(SUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[SUM_W-2:0], ge};
      rem_r <= ge ? PCNT_W'(trial - {1'b0, divisor}) : trial[PCNT_W-1:0];
    end
  end

endmodule
